### rtl/core/mah_pkg.sv
// package for the magnetometer calibration and heading block
// holds payload types, sequencer codes, fixed-point constants and the arctangent table
// no dependencies
package mah_pkg;

  localparam int DIV_BITS    = 33;
  localparam int CORDIC_W    = 34;
  localparam int CAL_W       = 24;
  localparam int DivConst    = 2000;
  localparam int ROUND_HALF  = 1000;
  localparam int SPAN_MIN_XY = 200;
  localparam int SPAN_MIN_Z  = 500;
  localparam int GAIN_ONE    = 4096;
  localparam int DEG_FULL    = 36000;
  localparam int RESET_SPAN_DEF   = 2000;
  localparam int CORDIC_STEPS_DEF = 16;

  // n / 2000 = ((n >> 4) * RECIP_MUL) >> RECIP_SHIFT, exact for n below 2^33
  localparam int DIV_PRE_SHIFT = 4;
  localparam int RECIP_MUL     = 549755814;
  localparam int RECIP_SHIFT   = 36;

  typedef struct packed {
    logic              new_sample;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_t;

  typedef struct packed {
    logic               fresh;
    logic signed [23:0] cal_x;
    logic signed [23:0] cal_y;
    logic signed [23:0] cal_z;
    logic [15:0]        heading;
  } out_t;

  typedef enum logic [2:0] {
    REG_AUTO, REG_CX, REG_CY, REG_CZ, REG_GX, REG_GY, REG_GZ, REG_DECL
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEARN, ST_GCHK, ST_GDIV, ST_GSTORE, ST_MUL, ST_CLOAD, ST_CDIV,
    ST_CSTORE, ST_CINIT, ST_CSTEP, ST_HMUL, ST_HFIN, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LEARN, OP_GLOAD, OP_DSTEP, OP_GSTORE, OP_MUL, OP_CLOAD,
    OP_CSTORE, OP_CINIT, OP_CSTEP, OP_HMUL, OP_HFIN, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic upd;
  } sts_t;

  function automatic logic [31:0] atan_of(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/magnetometer_autocal_heading.sv
// Magnetometer hard/soft-iron calibration with a CORDIC heading. Each input transfer is one
// sensor event; a flagged sample replaces the cached X/Y/Z readings and, in auto mode, widens
// the per-axis min/max from which center and gain are learned. Every input yields exactly one
// result: calibrated X/Y/Z and a heading in hundredths of a degree, 0..35999. One item is in
// work at a time; learning a new gain adds a divider pass and a store. Each item passes through
// the divide by 2000, a reciprocal multiply shared by the three axes (run once more for the
// gain), the shared axis multiplier and CORDIC_STEPS iterations of the CORDIC. A finished
// result waits in an output register, so the next input is taken while it is pending.
// Configuration writes are always ready and must be made only while the block is idle.
module magnetometer_autocal_heading #(
  parameter int RESET_SPAN   = mah_pkg::RESET_SPAN_DEF,
  parameter int CORDIC_STEPS = mah_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mah_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mah_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [16:0]   cfg_data
);
  import mah_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mah_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mah_dp #(
    .RESET_SPAN(RESET_SPAN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### rtl/core/mah_ctrl.sv
// sequencer for the magnetometer calibration and heading block
// steps the datapath through learn, divide, multiply and cordic phases; uses mah_pkg
module mah_ctrl #(
  parameter int CORDIC_STEPS = mah_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mah_pkg::sts_t sts,
  output mah_pkg::cmd_t cmd
);
  import mah_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.idx       = cnt_r[4:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_LEARN;
        end
      end
      ST_LEARN: begin
        cmd.op    = OP_LEARN;
        state_nxt = ST_GCHK;
      end
      ST_GCHK: begin
        cnt_nxt = '0;
        if (sts.upd) begin
          cmd.op    = OP_GLOAD;
          state_nxt = ST_GDIV;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_GDIV: begin
        cmd.op = OP_DSTEP;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_GSTORE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_GSTORE: begin
        cmd.op    = OP_GSTORE;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_CLOAD;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_CLOAD: begin
        cmd.op    = OP_CLOAD;
        cnt_nxt   = '0;
        state_nxt = ST_CDIV;
      end
      ST_CDIV: begin
        cmd.op = OP_DSTEP;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_CSTORE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_CSTORE: begin
        cmd.op    = OP_CSTORE;
        state_nxt = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.op    = OP_CINIT;
        cnt_nxt   = '0;
        state_nxt = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.op = OP_CSTEP;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_HMUL;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_HMUL: begin
        cmd.op    = OP_HMUL;
        state_nxt = ST_HFIN;
      end
      ST_HFIN: begin
        cmd.op    = OP_HFIN;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/mah_dp.sv
// datapath for the magnetometer calibration and heading block
// config registers, min/max learning, reciprocal divider, multiplier, cordic; uses mah_pkg
module mah_dp #(
  parameter int RESET_SPAN = mah_pkg::RESET_SPAN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mah_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [16:0]   cfg_data,
  input  mah_pkg::cmd_t cmd,
  output mah_pkg::sts_t sts,
  output mah_pkg::out_t out_data
);
  import mah_pkg::*;

  // configuration
  logic               auto_r;
  logic signed [16:0] mctr_r [3];
  logic [15:0]        mgain_r [3];
  logic signed [15:0] decl_r;

  // learning state
  logic signed [15:0] last_r [3];
  logic signed [15:0] min_r [3];
  logic signed [15:0] max_r [3];
  logic signed [16:0] lctr_r [3];
  logic [15:0]        lgain_r [3];
  logic [15:0]        span_r [3];
  logic               fresh_r;
  logic               upd_r;

  // arithmetic
  logic signed [33:0]         prod_r [3];
  logic                       neg_r [3];
  logic [DIV_BITS-1:0]        dq_r [3];
  logic signed [CAL_W-1:0]    cal_r [3];
  logic signed [CORDIC_W-1:0] x_r, y_r;
  logic [31:0]                ang_r;
  logic                       zero_r;
  logic [15:0]                h_r;
  logic [15:0]                head_r;
  out_t                       out_r;

  // learn combinational
  logic signed [15:0] nmin [3];
  logic signed [15:0] nmax [3];
  logic [15:0]        span [3];
  logic               widened, over, enough;

  always_comb begin
    widened = 1'b0;
    over    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      nmin[k] = (last_r[k] < min_r[k]) ? last_r[k] : min_r[k];
      nmax[k] = (last_r[k] > max_r[k]) ? last_r[k] : max_r[k];
      if (last_r[k] < min_r[k] || last_r[k] > max_r[k]) widened = 1'b1;
      span[k] = 16'(17'(nmax[k]) - 17'(nmin[k]));
      if (17'(span[k]) > 17'(RESET_SPAN)) over = 1'b1;
    end
    enough = (span[0] > 16'(SPAN_MIN_XY)) && (span[1] > 16'(SPAN_MIN_XY))
          && (span[2] > 16'(SPAN_MIN_Z));
  end

  // multiplier operands for the selected axis
  logic [1:0]         ax;
  logic signed [15:0] m_raw;
  logic signed [16:0] m_ctr;
  logic [15:0]        m_gain;
  logic signed [17:0] m_diff;
  logic signed [33:0] m_prod;

  assign ax = cmd.idx[1:0];

  // divide by 2000 for the selected lane: shift by 4, then multiply by 1/125
  logic [DIV_BITS-DIV_PRE_SHIFT-1:0] d_num;
  logic [58:0]                       d_prod;
  logic [DIV_BITS-1:0]               d_quo;

  always_comb begin
    case (ax)
      2'd0:    d_num = dq_r[0][DIV_BITS-1:DIV_PRE_SHIFT];
      2'd1:    d_num = dq_r[1][DIV_BITS-1:DIV_PRE_SHIFT];
      default: d_num = dq_r[2][DIV_BITS-1:DIV_PRE_SHIFT];
    endcase
    d_prod = 59'(d_num) * 59'(RECIP_MUL);
    d_quo  = DIV_BITS'(d_prod[58:RECIP_SHIFT]);
  end

  always_comb begin
    case (ax)
      2'd0: begin
        m_raw  = last_r[0];
        m_ctr  = auto_r ? lctr_r[0] : mctr_r[0];
        m_gain = auto_r ? lgain_r[0] : mgain_r[0];
      end
      2'd1: begin
        m_raw  = last_r[1];
        m_ctr  = auto_r ? lctr_r[1] : mctr_r[1];
        m_gain = auto_r ? lgain_r[1] : mgain_r[1];
      end
      default: begin
        m_raw  = last_r[2];
        m_ctr  = auto_r ? lctr_r[2] : mctr_r[2];
        m_gain = auto_r ? lgain_r[2] : mgain_r[2];
      end
    endcase
    m_diff = {m_raw[15], m_raw, 1'b0} - 18'(m_ctr);
    m_prod = 34'(m_diff) * $signed({18'b0, m_gain});
  end

  // cordic step
  logic signed [CORDIC_W-1:0] xs, ys, x0, y0;

  assign xs = x_r >>> cmd.idx;
  assign ys = y_r >>> cmd.idx;
  assign x0 = {{2{cal_r[0][CAL_W-1]}}, cal_r[0], 8'b0};
  assign y0 = {{2{cal_r[1][CAL_W-1]}}, cal_r[1], 8'b0};

  logic [47:0]        hprod;
  logic signed [17:0] hsum;

  assign hprod = {16'b0, ang_r} * 48'(DEG_FULL) + 48'h80000000;
  assign hsum  = $signed({2'b0, h_r}) + 18'(decl_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r <= 1'b1;
      decl_r <= '0;
      for (int k = 0; k < 3; k++) begin
        mctr_r[k]  <= '0;
        mgain_r[k] <= 16'(GAIN_ONE);
      end
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_AUTO: auto_r     <= cfg_data[0];
        REG_CX:   mctr_r[0]  <= cfg_data;
        REG_CY:   mctr_r[1]  <= cfg_data;
        REG_CZ:   mctr_r[2]  <= cfg_data;
        REG_GX:   mgain_r[0] <= cfg_data[15:0];
        REG_GY:   mgain_r[1] <= cfg_data[15:0];
        REG_GZ:   mgain_r[2] <= cfg_data[15:0];
        REG_DECL: decl_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // learning state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        last_r[k]  <= '0;
        min_r[k]   <= 16'sh7FFF;
        max_r[k]   <= 16'sh8000;
        lctr_r[k]  <= '0;
        lgain_r[k] <= 16'(GAIN_ONE);
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          upd_r <= 1'b0;
          if (in_data.new_sample) begin
            last_r[0] <= in_data.raw_x;
            last_r[1] <= in_data.raw_y;
            last_r[2] <= in_data.raw_z;
          end
        end
        OP_LEARN: begin
          if (fresh_r && auto_r && widened) begin
            for (int k = 0; k < 3; k++) begin
              span_r[k] <= span[k];
              if (over) begin
                min_r[k] <= 16'sh7FFF;
                max_r[k] <= 16'sh8000;
              end else begin
                min_r[k] <= nmin[k];
                max_r[k] <= nmax[k];
                if (enough) lctr_r[k] <= 17'(nmax[k]) + 17'(nmin[k]);
              end
            end
            upd_r <= !over && enough;
          end
        end
        OP_GSTORE: begin
          for (int k = 0; k < 3; k++)
            lgain_r[k] <= (|dq_r[k][DIV_BITS-1:16]) ? 16'hFFFF : dq_r[k][15:0];
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: fresh_r <= in_data.new_sample;
      OP_GLOAD: begin
        for (int k = 0; k < 3; k++)
          dq_r[k] <= DIV_BITS'({span_r[k], 12'b0}) + DIV_BITS'(ROUND_HALF);
      end
      OP_DSTEP: begin
        case (ax)
          2'd0:    dq_r[0] <= d_quo;
          2'd1:    dq_r[1] <= d_quo;
          default: dq_r[2] <= d_quo;
        endcase
      end
      OP_MUL: begin
        case (ax)
          2'd0:    prod_r[0] <= m_prod;
          2'd1:    prod_r[1] <= m_prod;
          default: prod_r[2] <= m_prod;
        endcase
      end
      OP_CLOAD: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= prod_r[k][33];
          dq_r[k]  <= DIV_BITS'((prod_r[k][33] ? -prod_r[k] : prod_r[k])
                               + 34'(ROUND_HALF));
        end
      end
      OP_CSTORE: begin
        for (int k = 0; k < 3; k++)
          cal_r[k] <= neg_r[k] ? -dq_r[k][CAL_W-1:0] : dq_r[k][CAL_W-1:0];
      end
      OP_CINIT: begin
        zero_r <= (cal_r[0] == '0) && (cal_r[1] == '0);
        if (x0[CORDIC_W-1]) begin
          x_r   <= -x0;
          y_r   <= -y0;
          ang_r <= 32'h80000000;
        end else begin
          x_r   <= x0;
          y_r   <= y0;
          ang_r <= '0;
        end
      end
      OP_CSTEP: begin
        if (!zero_r) begin
          if (!y_r[CORDIC_W-1]) begin
            x_r   <= x_r + ys;
            y_r   <= y_r - xs;
            ang_r <= ang_r + atan_of(cmd.idx);
          end else begin
            x_r   <= x_r - ys;
            y_r   <= y_r + xs;
            ang_r <= ang_r - atan_of(cmd.idx);
          end
        end
      end
      OP_HMUL: h_r <= hprod[47:32];
      OP_HFIN: begin
        if (hsum < 0)
          head_r <= 16'(hsum + 18'(DEG_FULL));
        else if (hsum >= 18'(DEG_FULL))
          head_r <= 16'(hsum - 18'(DEG_FULL));
        else
          head_r <= 16'(hsum);
      end
      OP_OUT: begin
        out_r.fresh   <= fresh_r;
        out_r.cal_x   <= cal_r[0];
        out_r.cal_y   <= cal_r[1];
        out_r.cal_z   <= cal_r[2];
        out_r.heading <= head_r;
      end
      default: ;
    endcase
  end

  assign sts.upd  = upd_r;
  assign out_data = out_r;

endmodule
